[rtl/core/cla_pkg.sv]
`timescale 1ns / 1ps

package cla_pkg;

	localparam int CHUNK_BYTES = 20480;
	localparam int MAX_CHUNKS  = 16;

	localparam int CHUNK_W  = 5;
	localparam int FILL_W   = 15;
	localparam int TOTAL_W  = 19;
	localparam int LEN_W    = 16;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 19;

	typedef enum logic [1:0] {
		MODE_BEGIN  = 2'd0,
		MODE_EVENT  = 2'd1,
		MODE_MARKER = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_IDLE     = 3'd1,
		ST_FULL     = 3'd2,
		ST_BAD_LEN  = 3'd3,
		ST_RESERVE  = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		CFG_CHUNKS  = 1'b0,
		CFG_RESERVE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [LEN_W-1:0]  line_length;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [3:0]        chunk_index;
		logic [FILL_W-1:0] write_offset;
		logic [31:0]       lines_stored;
		logic [TIME_W-1:0] covered_ms;
	} out_item_t;

	// allocator state; only the current chunk's fill is held, later chunks are empty
	typedef struct packed {
		logic [CHUNK_W-1:0] cur_chunk;
		logic [FILL_W-1:0]  cur_fill;
		logic [TOTAL_W-1:0] total_fill;
		logic [TIME_W-1:0]  start_time;
		logic [TIME_W-1:0]  last_time;
		logic [31:0]        line_total;
	} alloc_st_t;

endpackage

[rtl/core/cla_step.sv]
`timescale 1ns / 1ps

module cla_step import cla_pkg::*; (
	input  alloc_st_t          st,
	input  logic [CHUNK_W-1:0] chunks_present,
	input  logic [CFG_W-1:0]   reserve_bytes,
	input  in_item_t           item,
	output alloc_st_t          st_nxt,
	output out_item_t          res
);

	logic [CHUNK_W-1:0] cnt;
	logic [CHUNK_W-1:0] adv;
	logic [19:0]        cap;
	logic [19:0]        used;
	logic [19:0]        free_b;
	logic [16:0]        fill_sum;
	logic               is_begin;
	logic               is_event;
	logic               bad_len;
	logic               fits;
	logic               drop;
	logic [FILL_W-1:0]  offs;
	logic [CHUNK_W-1:0] tgt;
	status_t            stat;

	assign is_begin = (item.mode == MODE_BEGIN);
	assign is_event = (item.mode == MODE_EVENT);
	assign cnt      = (chunks_present > CHUNK_W'(MAX_CHUNKS)) ? CHUNK_W'(MAX_CHUNKS)
	                                                          : chunks_present;
	assign adv      = st.cur_chunk + CHUNK_W'(1);
	assign cap      = 20'(cnt * CHUNK_BYTES);
	assign used     = {1'b0, st.total_fill};
	assign free_b   = (cap > used) ? (cap - used) : '0;
	assign drop     = is_event && (free_b < {1'b0, reserve_bytes});
	assign bad_len  = (item.line_length == '0) || (item.line_length > LEN_W'(CHUNK_BYTES));
	assign fill_sum = {2'b0, st.cur_fill} + {1'b0, item.line_length};
	assign fits     = (fill_sum <= 17'(CHUNK_BYTES));
	assign tgt      = fits ? st.cur_chunk : adv;
	assign offs     = fits ? st.cur_fill : '0;

	always_comb begin
		st_nxt = st;
		stat   = ST_OK;
		priority if (is_begin) begin
			st_nxt.cur_chunk  = '0;
			st_nxt.cur_fill   = '0;
			st_nxt.total_fill = '0;
			st_nxt.line_total = '0;
			st_nxt.last_time  = '0;
			st_nxt.start_time = (item.now_ms == '0) ? TIME_W'(1) : item.now_ms;
		end else if (cnt == '0 || st.start_time == '0) begin
			stat = ST_IDLE;
		end else if (st.cur_chunk >= cnt) begin
			stat = ST_FULL;
		end else if (bad_len) begin
			stat = ST_BAD_LEN;
		end else if (drop) begin
			stat = ST_RESERVE;
		end else if (!fits && adv >= cnt) begin
			// overflow past the last chunk: stays full until the next begin
			stat             = ST_FULL;
			st_nxt.cur_chunk = adv;
			st_nxt.cur_fill  = '0;
		end else begin
			st_nxt.cur_chunk  = tgt;
			st_nxt.cur_fill   = offs + FILL_W'(item.line_length);
			st_nxt.total_fill = st.total_fill + TOTAL_W'(item.line_length);
			st_nxt.line_total = st.line_total + 32'd1;
			if (is_event) begin
				st_nxt.last_time = item.now_ms;
			end
		end
	end

	always_comb begin
		res              = '0;
		res.status       = stat;
		res.lines_stored = st_nxt.line_total;
		if (stat == ST_OK && !is_begin) begin
			res.chunk_index  = tgt[3:0];
			res.write_offset = offs;
		end
		if (st_nxt.last_time != '0 && st_nxt.start_time != '0
		    && st_nxt.last_time >= st_nxt.start_time) begin
			res.covered_ms = st_nxt.last_time - st_nxt.start_time;
		end
	end

endmodule

[rtl/core/chunked_log_write_allocator.sv]
`timescale 1ns / 1ps

// channel | direction | handshake           | payload
// in      | in        | in_valid / in_ready | in_data (in_item_t)
// out     | out       | out_valid/out_ready | out_data (out_item_t)
// cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// One word per cycle while out_ready holds; words pass item_s1, then res_s2.
// The rate is set by the state update loop through cla_step and st_q.
// arst_n clears the allocator state and both valid flags; reserve resets to 1024.
// A stalled result register holds the input register, which then stalls in_ready.

module chunked_log_write_allocator import cla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CHUNK_W-1:0] chunks_q;
	logic [CFG_W-1:0]   reserve_q;
	alloc_st_t          st_q;
	alloc_st_t          st_nxt;
	in_item_t           item_s1;
	logic               vld_s1;
	out_item_t          res;
	out_item_t          res_s2;
	logic               vld_s2;
	logic               adv_s1;

	assign adv_s1    = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready  = !vld_s1 || adv_s1;
	assign out_valid = vld_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunks_q  <= '0;
			reserve_q <= CFG_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHUNKS:  chunks_q  <= cfg_data[CHUNK_W-1:0];
				CFG_RESERVE: reserve_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	cla_step u_step (
		.st             (st_q),
		.chunks_present (chunks_q),
		.reserve_bytes  (reserve_q),
		.item           (item_s1),
		.st_nxt         (st_nxt),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			st_q   <= '0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv_s1) begin
				vld_s2 <= 1'b1;
				st_q   <= st_nxt;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

endmodule

[rtl/core/cla_checker.sv]
`timescale 1ns / 1ps

module cla_checker import cla_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two words in flight");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result word without an input word");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
		out_data.chunk_index == '0 && out_data.write_offset == '0)
		else $error("rejected word carries a write place");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.write_offset < FILL_W'(CHUNK_BYTES))
		else $error("write offset beyond chunk");

endmodule

bind chunked_log_write_allocator cla_checker u_cla_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
